@@ rtl/core/hsr_pkg.sv @@
`default_nettype none

package hsr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_STEPS  = 40;
   localparam int RADICAND_W = 32;
   localparam int ROOT_W     = 24;
   localparam int TOL_W      = 16;
   localparam int GUESS_W    = 32;
   localparam int SCALED_W   = RADICAND_W + FRAC_BITS;
   localparam int STEP_W     = $clog2(MAX_STEPS + 1);
   localparam int DIV_CNT_W  = $clog2(SCALED_W);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_STOP_TOL = '0;
   localparam logic [TOL_W-1:0]     TOL_RESET        = TOL_W'(1);

   localparam logic [GUESS_W-1:0] GUESS_ONE = GUESS_W'(1) << FRAC_BITS;
   localparam logic [ROOT_W-1:0]  ROOT_MAX  = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MEAN,
      ST_DIFF,
      ST_CHECK
   } hsr_state_type;

endpackage

`default_nettype wire

@@ rtl/core/hsr_csr.sv @@
`default_nettype none

module hsr_csr
   import hsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [TOL_W-1:0]      stop_tol
);

   logic [TOL_W-1:0]     tol_ff;
   logic [TOL_W-1:0]     tol_in;
   logic [CSR_IDX_W-1:0] index;
   logic                 wr_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      tol_in = tol_ff;
      if (wr_en && index == CSR_IDX_STOP_TOL) begin
         tol_in = csr_pwdata[TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   always_comb begin
      unique case (index)
         CSR_IDX_STOP_TOL: csr_prdata = CSR_DATA_W'(tol_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign stop_tol = tol_ff;

endmodule

`default_nettype wire

@@ rtl/core/hsr_divider.sv @@
`default_nettype none

module hsr_divider
   import hsr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                div_start,
   input  wire logic [SCALED_W-1:0] div_dividend,
   input  wire logic [GUESS_W-1:0]  div_divisor,
   output logic                     div_done,
   output logic      [SCALED_W-1:0] div_quotient
);

   logic                 run_ff;
   logic                 run_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic [SCALED_W-1:0]  work_ff;
   logic [SCALED_W-1:0]  work_in;
   logic [GUESS_W-1:0]   rem_ff;
   logic [GUESS_W-1:0]   rem_in;
   logic [GUESS_W-1:0]   dvs_ff;
   logic [GUESS_W-1:0]   dvs_in;
   logic [GUESS_W:0]     shifted;
   logic [GUESS_W:0]     trial;
   logic                 fits;

   assign shifted  = {rem_ff, work_ff[SCALED_W-1]};
   assign trial    = shifted - {1'b0, dvs_ff};
   assign fits     = shifted >= {1'b0, dvs_ff};
   assign div_done = run_ff && cnt_ff == DIV_CNT_W'(SCALED_W - 1);

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         work_in = div_dividend;
         rem_in  = '0;
         dvs_in  = div_divisor;
      end else if (run_ff) begin
         work_in = {work_ff[SCALED_W-2:0], fits};
         rem_in  = fits ? trial[GUESS_W-1:0] : shifted[GUESS_W-1:0];
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (div_done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_quotient = work_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

@@ rtl/core/heron_square_root_unit.sv @@
// Square root of an unsigned Q16.16 value by Heron's iteration, one result per
// transfer. Each iteration step runs a bit-serial restoring division of 48
// quotient bits, one bit per cycle, followed by the states for the mean, the
// change and the stop decision (ST_MEAN, ST_DIFF, ST_CHECK); an item takes at
// most 40 steps. A zero radicand returns in the cycle after it is accepted.
// busy stays high while an item is in work; the result appears on rsp_root and
// rsp_hit_step_cap for exactly one cycle with rsp_valid and must be taken then,
// since the receiver cannot stall the block.
`default_nettype none

module heron_square_root_unit
   import hsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [RADICAND_W-1:0] req_radicand,
   output logic                       rsp_valid,
   output logic      [ROOT_W-1:0]     rsp_root,
   output logic                       rsp_hit_step_cap,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   hsr_state_type          state_ff;
   hsr_state_type          state_in;
   logic [STEP_W-1:0]      step_ff;
   logic [STEP_W-1:0]      step_in;
   logic [RADICAND_W-1:0]  radicand_ff;
   logic [RADICAND_W-1:0]  radicand_in;
   logic [GUESS_W-1:0]     guess_ff;
   logic [GUESS_W-1:0]     guess_in;
   logic [SCALED_W-1:0]    next_ff;
   logic [SCALED_W-1:0]    next_in;
   logic [SCALED_W-1:0]    diff_ff;
   logic [SCALED_W-1:0]    diff_in;
   logic                   ge_ff;
   logic                   ge_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [ROOT_W-1:0]      rsp_root_ff;
   logic [ROOT_W-1:0]      rsp_root_in;
   logic                   rsp_cap_ff;
   logic                   rsp_cap_in;

   logic                   div_start;
   logic [SCALED_W-1:0]    div_dividend;
   logic [GUESS_W-1:0]     div_divisor;
   logic                   div_done;
   logic [SCALED_W-1:0]    div_quotient;
   logic [TOL_W-1:0]       stop_tol;
   logic [SCALED_W:0]      mean_sum;
   logic [SCALED_W-1:0]    guess_ext;
   logic [SCALED_W-1:0]    root_sel;
   logic [ROOT_W-1:0]      root_sat;
   logic                   finish;
   logic                   accept;

   hsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .stop_tol    (stop_tol)
   );

   hsr_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   assign busy      = state_ff != ST_IDLE;
   assign accept    = start && !busy;
   assign guess_ext = SCALED_W'(guess_ff);
   assign mean_sum  = {1'b0, div_quotient} + (SCALED_W + 1)'(guess_ff);
   assign root_sat  = (root_sel > SCALED_W'(ROOT_MAX)) ? ROOT_MAX : root_sel[ROOT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      radicand_in  = radicand_ff;
      guess_in     = guess_ff;
      next_in      = next_ff;
      diff_in      = diff_ff;
      ge_in        = ge_ff;
      rsp_valid_in = 1'b0;
      rsp_root_in  = rsp_root_ff;
      rsp_cap_in   = rsp_cap_ff;
      div_start    = 1'b0;
      div_dividend = {radicand_ff, FRAC_BITS'(0)};
      div_divisor  = GUESS_ONE;
      root_sel     = next_ff;
      finish       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            div_dividend = {req_radicand, FRAC_BITS'(0)};
            if (accept) begin
               if (req_radicand == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = '0;
                  rsp_cap_in   = 1'b0;
               end else begin
                  radicand_in = req_radicand;
                  guess_in    = GUESS_ONE;
                  step_in     = STEP_W'(1);
                  div_start   = 1'b1;
                  state_in    = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            next_in  = mean_sum[SCALED_W:1];
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            ge_in    = next_ff >= guess_ext;
            diff_in  = (next_ff >= guess_ext) ? (next_ff - guess_ext) : (guess_ext - next_ff);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (diff_ff < SCALED_W'(stop_tol)) begin
               root_sel   = next_ff;
               rsp_cap_in = 1'b0;
               finish     = 1'b1;
            end else if (step_ff >= STEP_W'(2) && ge_ff) begin
               root_sel   = guess_ext;
               rsp_cap_in = 1'b0;
               finish     = 1'b1;
            end else if (step_ff == STEP_W'(MAX_STEPS)) begin
               guess_in   = next_ff[GUESS_W-1:0];
               root_sel   = next_ff;
               rsp_cap_in = 1'b1;
               finish     = 1'b1;
            end else begin
               guess_in     = next_ff[GUESS_W-1:0];
               step_in      = step_ff + STEP_W'(1);
               div_start    = 1'b1;
               div_divisor  = (next_ff[GUESS_W-1:0] == '0) ? GUESS_W'(1)
                                                           : next_ff[GUESS_W-1:0];
               state_in     = ST_DIV;
            end
            if (finish) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = root_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff <= radicand_in;
      guess_ff    <= guess_in;
      next_ff     <= next_in;
      diff_ff     <= diff_in;
      ge_ff       <= ge_in;
      rsp_root_ff <= rsp_root_in;
      rsp_cap_ff  <= rsp_cap_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root         = rsp_root_ff;
   assign rsp_hit_step_cap = rsp_cap_ff;

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result presented while an item is still in work");

   a_zero_radicand: assert property (@(posedge clock) disable iff (reset)
      (accept && req_radicand == '0) |=> (rsp_valid && rsp_root == '0 && !rsp_hit_step_cap))
      else $error("zero radicand did not return zero at once");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (step_ff >= STEP_W'(1) && step_ff <= STEP_W'(MAX_STEPS)))
      else $error("step count outside its range");

   a_cap_only_at_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && finish && rsp_cap_in) |-> step_ff == STEP_W'(MAX_STEPS))
      else $error("step cap flagged before the last step");

endmodule

`default_nettype wire

@@ bench/heron_root_checker.sv @@
module heron_root_checker
   import hsr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  busy,
   input  wire logic [RADICAND_W-1:0] req_radicand,
   input  wire logic                  rsp_valid,
   input  wire logic [ROOT_W-1:0]     rsp_root,
   input  wire logic                  rsp_hit_step_cap,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                  csr_pready,
   output int                         pending_roots,
   output int                         mismatch_count
);

   typedef struct packed {
      logic [RADICAND_W-1:0] radicand;
      logic [ROOT_W-1:0]     root;
      logic                  hit_step_cap;
   } root_entry_type;

   root_entry_type   awaited_roots[$];
   logic [TOL_W-1:0] tolerance;

   function automatic root_entry_type heron_root(input logic [RADICAND_W-1:0] radicand,
                                                 input logic [TOL_W-1:0]      tol);
      root_entry_type result;
      logic [63:0] scaled;
      logic [63:0] guess;
      logic [63:0] next_guess;
      logic [63:0] divisor;
      logic [63:0] change;
      logic [63:0] root;
      bit          done;
      result.radicand = radicand;
      result.root = '0;
      result.hit_step_cap = 1'b0;
      if (radicand == '0) begin
         return result;
      end
      scaled = 64'(radicand) << FRAC_BITS;
      guess = 64'(1) << FRAC_BITS;
      root = guess;
      done = 1'b0;
      for (int step = 1; step <= MAX_STEPS && !done; step++) begin
         divisor = (guess == 0) ? 64'(1) : guess;
         next_guess = (guess + scaled / divisor) >> 1;
         change = (next_guess >= guess) ? next_guess - guess : guess - next_guess;
         if (change < 64'(tol)) begin
            root = next_guess;
            done = 1'b1;
         end else if (step >= 2 && next_guess >= guess) begin
            root = guess;
            done = 1'b1;
         end else begin
            guess = next_guess;
            root = guess;
         end
      end
      result.hit_step_cap = !done;
      result.root = (root > 64'(ROOT_MAX)) ? ROOT_MAX : root[ROOT_W-1:0];
      return result;
   endfunction

   always @(posedge clock) begin
      root_entry_type want;
      int             errors;
      errors = 0;
      if (reset) begin
         tolerance = TOL_RESET;
         awaited_roots.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_STOP_TOL) begin
            if (csr_pwrite) begin
               tolerance = csr_pwdata[TOL_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(tolerance)) begin
               $display("%0t: tolerance readback expected %h, got %h",
                        $time, CSR_DATA_W'(tolerance), csr_prdata);
               errors++;
            end
         end
         if (start && !busy) begin
            awaited_roots.push_back(heron_root(req_radicand, tolerance));
         end
         if (rsp_valid) begin
            if (awaited_roots.size() == 0) begin
               $display("%0t: unexpected root transfer: expected none, got root %h cap %b",
                        $time, rsp_root, rsp_hit_step_cap);
               errors++;
            end else begin
               want = awaited_roots.pop_front();
               if (rsp_root !== want.root) begin
                  $display("%0t: root of %h: expected %h, got %h",
                           $time, want.radicand, want.root, rsp_root);
                  errors++;
               end
               if (rsp_hit_step_cap !== want.hit_step_cap) begin
                  $display("%0t: step cap flag of %h: expected %b, got %b",
                           $time, want.radicand, want.hit_step_cap, rsp_hit_step_cap);
                  errors++;
               end
            end
         end
      end
      pending_roots <= awaited_roots.size();
      mismatch_count <= mismatch_count + errors;
   end

endmodule

@@ bench/heron_square_root_unit_tb.sv @@
module heron_square_root_unit_tb;
   import hsr_pkg::*;

   localparam int LIMIT_CYCLES    = 6_000_000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASE_COUNT     = 6;
   localparam int CORNER_COUNT    = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = CSR_IDX_STOP_TOL + 1'b1;

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic [RADICAND_W-1:0] req_radicand     = '0;
   logic                  rsp_valid;
   logic [ROOT_W-1:0]     rsp_root;
   logic                  rsp_hit_step_cap;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int pending_roots;
   int mismatch_count;
   int cycle_count = 0;
   int idle_pct    = 0;

   heron_square_root_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_radicand     (req_radicand),
      .rsp_valid        (rsp_valid),
      .rsp_root         (rsp_root),
      .rsp_hit_step_cap (rsp_hit_step_cap),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   heron_root_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_radicand     (req_radicand),
      .rsp_valid        (rsp_valid),
      .rsp_root         (rsp_root),
      .rsp_hit_step_cap (rsp_hit_step_cap),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .pending_roots    (pending_roots),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("heron_square_root_unit_tb failed");
         $finish;
      end
   end

   function automatic logic [RADICAND_W-1:0] corner_radicand(input int index);
      case (index)
         0:       return 32'h0000_0000;
         1:       return 32'h0000_0001;
         2:       return 32'h0000_0002;
         3:       return 32'h0000_0003;
         4:       return 32'h0000_0004;
         5:       return 32'h0000_0100;
         6:       return 32'h0000_4000;
         7:       return 32'h0000_FFFF;
         8:       return 32'h0001_0000;
         9:       return 32'h0001_0001;
         10:      return 32'h0004_0000;
         11:      return 32'h0009_0000;
         12:      return 32'h5555_5555;
         13:      return 32'h7FFF_FFFF;
         14:      return 32'h8000_0000;
         15:      return 32'hAAAA_AAAA;
         16:      return 32'hFFFF_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [RADICAND_W-1:0] pick_radicand();
      logic [RADICAND_W-1:0] base;
      case ($urandom_range(9))
         0:          return '0;
         1, 2, 3, 4: return RADICAND_W'($urandom);
         9: begin
            base = RADICAND_W'($urandom_range(65535));
            return base * base + RADICAND_W'($urandom_range(2)) - 1'b1;
         end
         default:    return RADICAND_W'($urandom) >> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [TOL_W-1:0] phase_tolerance(input int phase);
      case (phase)
         0:       return '0;
         1:       return '1;
         2:       return TOL_W'($urandom_range(2, 64));
         3:       return TOL_W'(1);
         4:       return TOL_W'($urandom);
         default: return TOL_W'(2);
      endcase
   endfunction

   function automatic int phase_idle_pct(input int phase);
      case (phase)
         1, 4:    return 70;
         3, 5:    return 11;
         default: return 0;
      endcase
   endfunction

   task automatic csr_access(input logic write, input logic [CSR_IDX_W-1:0] index,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic transfer_radicand(input logic [RADICAND_W-1:0] value);
      req_radicand <= value;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_radicand <= RADICAND_W'($urandom);
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_roots != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, CSR_IDX_STOP_TOL, '0);
      for (int i = 0; i < CORNER_COUNT; i++) begin
         transfer_radicand(corner_radicand(i));
      end
      drain();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         csr_access(1'b1, CSR_IDX_STOP_TOL, {16'($urandom), phase_tolerance(phase)});
         if (phase == 3) begin
            // A write to the spare index must leave the tolerance untouched.
            csr_access(1'b1, CSR_IDX_UNUSED, CSR_DATA_W'($urandom));
         end
         csr_access(1'b0, CSR_IDX_STOP_TOL, '0);
         idle_pct = phase_idle_pct(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            transfer_radicand(pick_radicand());
         end
         drain();
      end
      if (mismatch_count == 0 && pending_roots == 0) begin
         $display("heron_square_root_unit_tb passed");
      end else begin
         $display("heron_square_root_unit_tb failed");
      end
      $finish;
   end

endmodule
